FILE: rtl/core/minv_pkg.sv
`default_nettype none

package minv_pkg;

    // Element and intermediate widths.
    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ADJ_W  = PROD_W + 1;
    localparam int PART_W = ELEM_W + ELEM_W + 1;
    localparam int DET_W  = 99;
    localparam int DMAG_W = DET_W - 1;
    localparam int REM_W  = DMAG_W + 1;
    localparam int QBITS  = 32;
    localparam int NELEM  = 9;

    // Pipeline layout: front stages, divider stages, output stage.
    localparam int FRONT  = 6;
    localparam int DIV_ST = QBITS + 1;
    localparam int NST    = FRONT + DIV_ST + 1;

    // Adjugate terms, flat index r*3+c: adj = m[a]*m[b] - m[c]*m[d].
    localparam logic [3:0] ADJ_IDX [NELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Adjugate entries that pair with row 0 in the determinant expansion.
    localparam logic [3:0] DET_ADJ [3] = '{4'd0, 4'd3, 4'd6};

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [DIV_ST-1:0]        div_adv_t;

endpackage

`default_nettype wire

FILE: rtl/core/matrix_inverse_3x3_unit.sv
// Throughput: one matrix per cycle while the output does not stall. Each quotient
// comes from a 33-stage restoring divider pipeline, nine in parallel: its first
// stage flags an oversized quotient, each later stage adds one quotient bit. Stages
// advance on their own, so bubbles close up while the output stalls. Reset
// (rst_n, asynchronous, active low) empties the pipeline valid bits.
`default_nettype none

module matrix_inverse_3x3_unit
    import minv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [31:0] in_r0c0,
    input  wire logic signed [31:0] in_r0c1,
    input  wire logic signed [31:0] in_r0c2,
    input  wire logic signed [31:0] in_r1c0,
    input  wire logic signed [31:0] in_r1c1,
    input  wire logic signed [31:0] in_r1c2,
    input  wire logic signed [31:0] in_r2c0,
    input  wire logic signed [31:0] in_r2c1,
    input  wire logic signed [31:0] in_r2c2,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     inv_r0c0,
    output logic signed [31:0]     inv_r0c1,
    output logic signed [31:0]     inv_r0c2,
    output logic signed [31:0]     inv_r1c0,
    output logic signed [31:0]     inv_r1c1,
    output logic signed [31:0]     inv_r1c2,
    output logic signed [31:0]     inv_r2c0,
    output logic signed [31:0]     inv_r2c1,
    output logic signed [31:0]     inv_r2c2,
    output logic                   singular,
    output logic                   overflow
);

    elem_t mat [NELEM];

    logic [NST-1:0] valid_reg;
    logic [NST:0]   adv;

    assign mat[0] = in_r0c0;
    assign mat[1] = in_r0c1;
    assign mat[2] = in_r0c2;
    assign mat[3] = in_r1c0;
    assign mat[4] = in_r1c1;
    assign mat[5] = in_r1c2;
    assign mat[6] = in_r2c0;
    assign mat[7] = in_r2c1;
    assign mat[8] = in_r2c2;

    // A stage takes new data when it is empty or its content moves on.
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 0: the eighteen cofactor products.
    logic signed [PROD_W-1:0] prod_a_reg [NELEM];
    logic signed [PROD_W-1:0] prod_b_reg [NELEM];
    elem_t                    row0_reg   [3];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                prod_a_reg[k] <= PROD_W'(mat[ADJ_IDX[k][0]]) * PROD_W'(mat[ADJ_IDX[k][1]]);
                prod_b_reg[k] <= PROD_W'(mat[ADJ_IDX[k][2]]) * PROD_W'(mat[ADJ_IDX[k][3]]);
            end
            for (int c = 0; c < 3; c++)
            begin
                row0_reg[c] <= mat[c];
            end
        end
    end

    // Stage 1: adjugate entries at full width.
    logic signed [ADJ_W-1:0] adj1_reg [NELEM];
    elem_t                   row1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                adj1_reg[k] <= ADJ_W'(prod_a_reg[k]) - ADJ_W'(prod_b_reg[k]);
            end
            row1_reg <= row0_reg;
        end
    end

    // Stage 2: determinant partial products, adjugate split in two halves.
    logic signed [PART_W-1:0] plo_reg  [3];
    logic signed [PART_W-1:0] phi_reg  [3];
    logic signed [ADJ_W-1:0]  adj2_reg [NELEM];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                plo_reg[c] <= PART_W'(row1_reg[c])
                    * PART_W'($signed({1'b0, adj1_reg[DET_ADJ[c]][31:0]}));
                phi_reg[c] <= PART_W'(row1_reg[c])
                    * PART_W'($signed(adj1_reg[DET_ADJ[c]][ADJ_W-1:32]));
            end
            adj2_reg <= adj1_reg;
        end
    end

    // Stage 3: recombine the halves into the three expansion terms.
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [ADJ_W-1:0] adj3_reg [NELEM];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_reg[c] <= (DET_W'(phi_reg[c]) <<< 32) + DET_W'(plo_reg[c]);
            end
            adj3_reg <= adj2_reg;
        end
    end

    // Stage 4: the determinant.
    logic signed [DET_W-1:0] det_reg;
    logic signed [ADJ_W-1:0] adj4_reg [NELEM];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj4_reg <= adj3_reg;
        end
    end

    // Stage 5: magnitudes and result signs.
    logic              sing5_reg;
    logic [DMAG_W-1:0] dmag_reg;
    logic [ADJ_W-1:0]  nmag_reg [NELEM];
    logic              neg_reg  [NELEM];
    logic [DET_W-1:0]  det_abs;

    assign det_abs = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            sing5_reg <= (det_reg == '0);
            dmag_reg  <= det_abs[DMAG_W-1:0];
            for (int k = 0; k < NELEM; k++)
            begin
                nmag_reg[k] <= adj4_reg[k][ADJ_W-1] ? ADJ_W'(-adj4_reg[k])
                                                   : ADJ_W'(adj4_reg[k]);
                neg_reg[k]  <= adj4_reg[k][ADJ_W-1] ^ det_reg[DET_W-1];
            end
        end
    end

    // Divider stages: nine quotients in parallel.
    div_adv_t         div_adv;
    logic [QBITS-1:0] quot     [NELEM];
    logic             big      [NELEM];
    logic             neg_div  [NELEM];
    logic             sing_reg [DIV_ST];

    assign div_adv = adv[FRONT + DIV_ST - 1:FRONT];

    for (genvar k = 0; k < NELEM; k++)
    begin : g_div
        minv_div u_div (
            .clk     (clk),
            .adv     (div_adv),
            .nmag    (nmag_reg[k]),
            .dmag    (dmag_reg),
            .neg     (neg_reg[k]),
            .quot    (quot[k]),
            .big     (big[k]),
            .neg_out (neg_div[k])
        );
    end

    // The singular flag rides alongside the divider.
    always_ff @(posedge clk)
    begin
        if (div_adv[0])
        begin
            sing_reg[0] <= sing5_reg;
        end
        for (int s = 1; s < DIV_ST; s++)
        begin
            if (div_adv[s])
            begin
                sing_reg[s] <= sing_reg[s-1];
            end
        end
    end

    // Output stage: sign, saturation and the singular case.
    logic [ELEM_W-1:0] inv_next [NELEM];
    logic [NELEM-1:0]  sat;
    logic [ELEM_W-1:0] inv_reg  [NELEM];
    logic              sing_out_reg;
    logic              ovf_reg;

    always_comb
    begin
        for (int k = 0; k < NELEM; k++)
        begin
            if (neg_div[k])
            begin
                sat[k]      = big[k] || (quot[k] > 32'h8000_0000);
                inv_next[k] = sat[k] ? 32'h8000_0000 : ELEM_W'(-{1'b0, quot[k]});
            end
            else
            begin
                sat[k]      = big[k] || (quot[k] > 32'h7FFF_FFFF);
                inv_next[k] = sat[k] ? 32'h7FFF_FFFF : quot[k];
            end
            if (sing_reg[DIV_ST-1])
            begin
                sat[k]      = 1'b0;
                inv_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NST-1])
        begin
            inv_reg      <= inv_next;
            sing_out_reg <= sing_reg[DIV_ST-1];
            ovf_reg      <= |sat;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign inv_r0c0  = inv_reg[0];
    assign inv_r0c1  = inv_reg[1];
    assign inv_r0c2  = inv_reg[2];
    assign inv_r1c0  = inv_reg[3];
    assign inv_r1c1  = inv_reg[4];
    assign inv_r1c2  = inv_reg[5];
    assign inv_r2c0  = inv_reg[6];
    assign inv_r2c1  = inv_reg[7];
    assign inv_r2c2  = inv_reg[8];
    assign singular  = sing_out_reg;
    assign overflow  = ovf_reg;

    // A singular result is all zero and never flags overflow.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !overflow && inv_r0c0 == 0 && inv_r1c1 == 0
            && inv_r2c2 == 0 && inv_r0c2 == 0 && inv_r2c0 == 0)
        else $error("singular result is not zero");

    // Overflow means at least one element sits at a saturation limit.
    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            inv_r0c0 == 32'h7FFF_FFFF || inv_r0c0 == 32'h8000_0000 ||
            inv_r0c1 == 32'h7FFF_FFFF || inv_r0c1 == 32'h8000_0000 ||
            inv_r0c2 == 32'h7FFF_FFFF || inv_r0c2 == 32'h8000_0000 ||
            inv_r1c0 == 32'h7FFF_FFFF || inv_r1c0 == 32'h8000_0000 ||
            inv_r1c1 == 32'h7FFF_FFFF || inv_r1c1 == 32'h8000_0000 ||
            inv_r1c2 == 32'h7FFF_FFFF || inv_r1c2 == 32'h8000_0000 ||
            inv_r2c0 == 32'h7FFF_FFFF || inv_r2c0 == 32'h8000_0000 ||
            inv_r2c1 == 32'h7FFF_FFFF || inv_r2c1 == 32'h8000_0000 ||
            inv_r2c2 == 32'h7FFF_FFFF || inv_r2c2 == 32'h8000_0000)
        else $error("overflow without a saturated element");

    // An empty output stage never holds back new requests.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NST-1] |-> in_ready)
        else $error("input stalled with an empty output stage");

endmodule

`default_nettype wire

FILE: rtl/core/minv_div.sv
`default_nettype none

module minv_div
    import minv_pkg::*;
(
    input  wire logic              clk,
    input  wire div_adv_t          adv,
    input  wire logic [ADJ_W-1:0]  nmag,
    input  wire logic [DMAG_W-1:0] dmag,
    input  wire logic              neg,
    output logic [QBITS-1:0]       quot,
    output logic                   big,
    output logic                   neg_out
);

    logic [DMAG_W-1:0] rem_reg  [DIV_ST];
    logic [DMAG_W-1:0] dmag_reg [DIV_ST];
    logic [QBITS-1:0]  q_reg    [DIV_ST];
    logic              big_reg  [DIV_ST];
    logic              neg_reg  [DIV_ST];

    // First stage: a quotient of 2^32 or more shows as nmag >= dmag.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            big_reg[0]  <= ({{(DMAG_W-ADJ_W){1'b0}}, nmag} >= dmag);
            rem_reg[0]  <= {{(DMAG_W-ADJ_W){1'b0}}, nmag};
            dmag_reg[0] <= dmag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg;
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar k = 1; k < DIV_ST; k++)
    begin : g_step
        logic [REM_W-1:0]  shifted;
        logic              ge;
        logic [REM_W-1:0]  diff;

        always_comb
        begin
            shifted = {rem_reg[k-1], 1'b0};
            ge      = (shifted >= {1'b0, dmag_reg[k-1]});
            diff    = shifted - {1'b0, dmag_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rem_reg[k]  <= ge ? diff[DMAG_W-1:0] : shifted[DMAG_W-1:0];
                dmag_reg[k] <= dmag_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][QBITS-2:0], ge};
                big_reg[k]  <= big_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    assign quot    = q_reg[DIV_ST-1];
    assign big     = big_reg[DIV_ST-1];
    assign neg_out = neg_reg[DIV_ST-1];

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import minv_pkg::*;

    localparam int RAND_ITEMS = 440;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int unsigned Q_ONE = 32'h0001_0000;

    // Cofactor terms per inverse element, flat index r*3+c: p*q - r*s.
    localparam int COF_TERM [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic [8:0][31:0] mat_t;

    typedef struct packed {
        mat_t inv;
        logic sing;
        logic ovf;
    } inverse_t;

    typedef struct packed {
        mat_t     m;
        logic     typed;
        inverse_t res;
    } vector_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic out_ready;
    mat_t in_m;
    logic in_ready;
    logic out_valid;
    mat_t out_m;
    logic singular;
    logic overflow;

    inverse_t pending_inverses[$];
    vector_t  vectors[$];
    int       cycle;
    int       items_sent;
    bit       failed;

    matrix_inverse_3x3_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_r0c0  (in_m[0]),
        .in_r0c1  (in_m[1]),
        .in_r0c2  (in_m[2]),
        .in_r1c0  (in_m[3]),
        .in_r1c1  (in_m[4]),
        .in_r1c2  (in_m[5]),
        .in_r2c0  (in_m[6]),
        .in_r2c1  (in_m[7]),
        .in_r2c2  (in_m[8]),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .inv_r0c0 (out_m[0]),
        .inv_r0c1 (out_m[1]),
        .inv_r0c2 (out_m[2]),
        .inv_r1c0 (out_m[3]),
        .inv_r1c1 (out_m[4]),
        .inv_r1c2 (out_m[5]),
        .inv_r2c0 (out_m[6]),
        .inv_r2c1 (out_m[7]),
        .inv_r2c2 (out_m[8]),
        .singular (singular),
        .overflow (overflow)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Exact adjugate inverse with truncation toward zero and saturation.
    function automatic inverse_t invert_matrix(input mat_t m);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] nmag;
        logic [127:0] quot;
        logic neg;
        inverse_t r;
        begin
            r = '0;
            for (int k = 0; k < 9; k++)
                e[k] = {{96{m[k][31]}}, m[k]};
            for (int k = 0; k < 9; k++)
                cof[k] = e[COF_TERM[k][0]] * e[COF_TERM[k][1]]
                       - e[COF_TERM[k][2]] * e[COF_TERM[k][3]];
            det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
            if (det == 0)
            begin
                r.sing = 1'b1;
                return r;
            end
            dmag = det[127] ? -det : det;
            for (int k = 0; k < 9; k++)
            begin
                nmag = cof[k][127] ? -cof[k] : cof[k];
                quot = (nmag << 32) / dmag;
                neg = cof[k][127] ^ det[127];
                if (neg)
                begin
                    if (quot > 128'h8000_0000)
                    begin
                        r.inv[k] = 32'h8000_0000;
                        r.ovf = 1'b1;
                    end
                    else
                        r.inv[k] = -quot[31:0];
                end
                else if (quot > 128'h7FFF_FFFF)
                begin
                    r.inv[k] = 32'h7FFF_FFFF;
                    r.ovf = 1'b1;
                end
                else
                    r.inv[k] = quot[31:0];
            end
            return r;
        end
    endfunction

    function automatic mat_t diag(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c);
        mat_t m;
        begin
            m = '0;
            m[0] = a;
            m[4] = b;
            m[8] = c;
            return m;
        end
    endfunction

    function automatic inverse_t diag_inverse(input logic [31:0] v, input logic ovf);
        inverse_t r;
        begin
            r = '0;
            r.inv = diag(v, v, v);
            r.ovf = ovf;
            return r;
        end
    endfunction

    function automatic logic [31:0] rand_elem(input int kind);
        begin
            case (kind)
                0: return $urandom;
                1: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
                default: return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
            endcase
        end
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int pick;
        int kind;
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 50) ? 1 : (pick < 70) ? 0 : 2;
            for (int k = 0; k < 9; k++)
                m[k] = rand_elem(kind);
            // Some matrices are made singular by a repeated row or a zero column.
            if (pick >= 85)
            begin
                if ($urandom_range(0, 1))
                begin
                    m[6] = m[0];
                    m[7] = m[1];
                    m[8] = m[2];
                end
                else
                begin
                    m[1] = '0;
                    m[4] = '0;
                    m[7] = '0;
                end
            end
            return m;
        end
    endfunction

    // Present one request, optionally after an idle gap, and wait for acceptance.
    task automatic send_request(input mat_t m, input inverse_t res, input bit quiet);
        begin
            if (!quiet && $urandom_range(0, 99) < 10)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_m <= m;
            in_valid <= 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
            pending_inverses.push_back(res);
            items_sent++;
        end
    endtask

    // Output stall pattern, with a long stretch of no stalls.
    always @(posedge clk)
    begin
        if (items_sent > 150 && items_sent < 300)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 20);
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_inverses.size() == 0)
            begin
                $error("unexpected result with no request outstanding");
                failed = 1'b1;
            end
            else
            begin
                inverse_t exp_res;
                exp_res = pending_inverses.pop_front();
                for (int k = 0; k < 9; k++)
                    if (out_m[k] !== exp_res.inv[k])
                    begin
                        $error("inv_r%0dc%0d expected %h actual %h", k / 3, k % 3,
                               exp_res.inv[k], out_m[k]);
                        failed = 1'b1;
                    end
                if (singular !== exp_res.sing)
                begin
                    $error("singular expected %b actual %b", exp_res.sing, singular);
                    failed = 1'b1;
                end
                if (overflow !== exp_res.ovf)
                begin
                    $error("overflow expected %b actual %b", exp_res.ovf, overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("matrix_inverse_3x3_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        vector_t row;
        mat_t m;
        int drain;
        cycle = 0;
        items_sent = 0;
        failed = 1'b0;
        in_valid = 1'b0;
        in_m = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;

        // Directed table: typed expectations for zero, identity and extremes.
        row = '0;
        row.typed = 1'b1;
        row.res.sing = 1'b1;
        vectors.push_back(row);
        row.m = {9{32'h8000_0000}};
        vectors.push_back(row);
        row.m = {9{32'h7FFF_FFFF}};
        vectors.push_back(row);
        row.m = diag(Q_ONE, Q_ONE, Q_ONE);
        row.res = diag_inverse(Q_ONE, 1'b0);
        vectors.push_back(row);
        row.m = diag(32'd1, 32'd1, 32'd1);
        row.res = diag_inverse(32'h7FFF_FFFF, 1'b1);
        vectors.push_back(row);
        row.m = diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row.res = diag_inverse(32'h8000_0000, 1'b1);
        vectors.push_back(row);
        // Remaining directed rows go through the predictor.
        row = '0;
        row.m = diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        vectors.push_back(row);
        row.m = diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        vectors.push_back(row);
        row.m = diag(2 * Q_ONE, -4 * Q_ONE, Q_ONE / 2);
        vectors.push_back(row);
        row.m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                 32'h7FFF_FFFF};
        vectors.push_back(row);
        row.m = {Q_ONE, 32'h0, 32'h0, 3 * Q_ONE, Q_ONE, 32'h0, 5 * Q_ONE,
                 -2 * Q_ONE, Q_ONE};
        vectors.push_back(row);
        row.m = {32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                 32'hF0F0_F0F0};
        vectors.push_back(row);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send_request(vectors[i].m,
                         vectors[i].typed ? vectors[i].res : invert_matrix(vectors[i].m),
                         1'b0);

        // Random matrices; the middle stretch runs without input gaps.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            m = rand_matrix();
            send_request(m, invert_matrix(m), (i > 200 && i < 300));
        end
        in_valid <= 1'b0;

        while (pending_inverses.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        if (!failed)
            $display("matrix_inverse_3x3_unit regression: pass");
        else
            $display("matrix_inverse_3x3_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
